@@ rtl/plti_pkg.sv @@
// Shared types and constants for the piecewise-linear table interpolator.
package plti_pkg;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Quotient of the interval division always fits 32 bits.
  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [2:0] {
    STATUS_INTERIOR   = 3'd0,
    STATUS_CLAMP_LOW  = 3'd1,
    STATUS_CLAMP_HIGH = 3'd2,
    STATUS_EMPTY      = 3'd3,
    STATUS_NOT_FOUND  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_FIRST,
    SEQ_LAST,
    SEQ_SCAN,
    SEQ_LERP
  } seq_state_e;

  typedef enum logic [2:0] {
    LERP_IDLE,
    LERP_PREP,
    LERP_MUL,
    LERP_DIV,
    LERP_FIN
  } lerp_phase_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  typedef struct packed {
    logic               start;
    point_t             pa;
    point_t             pb;
    logic signed [31:0] q;
  } lerp_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } lerp_rsp_t;

endpackage

@@ rtl/piecewise_linear_table_interp.sv @@
// Top level: piecewise-linear table interpolator with scan sequencer.
//
// Usage. An item is taken when start is high and busy is low. mode_i = 0
// loads point (point_x_i, point_y_i) into slot point_index_i at that edge;
// busy stays low and no result follows. mode_i = 1 queries at query_x_i
// over the first points_in_use slots (cfg_we_i / cfg_wdata_i, to be written
// only while idle; the block itself does not enforce this). Each query gives
// one result: result_valid_o is high for one cycle with result_value_o and
// status_o; the receiver cannot stall it. On an empty table the result
// follows in the next cycle with busy never raised. Otherwise entry 0 is
// checked for clamp low, then the last entry for clamp high, then the scan
// reads one table entry per cycle through the single read port; an interior
// hit runs the interpolation unit (operand prep, one 32x32 multiply, a
// 32-step restoring divide, final add); a zero-width interval skips the
// divide. Reset clears the point count to zero and returns the sequencer
// to idle; table contents are undefined until loaded.
module piecewise_linear_table_interp #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [5:0]  point_index_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] query_x_i,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  output logic        result_valid_o,
  output logic signed [31:0] result_value_o,
  output logic [2:0]  status_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  plti_pkg::seq_state_e state_q, state_d;

  logic [6:0]         points_q;
  logic [6:0]         n_pts;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      idx_q;
  logic signed [31:0] query_q;
  plti_pkg::point_t   prev_q;
  plti_pkg::point_t   rd_data;
  plti_pkg::point_t   wr_data;

  logic               res_valid_q;
  logic signed [31:0] res_value_q;
  plti_pkg::status_e  res_status_q;

  logic               accept, is_query, wr_en;
  logic               le_first, ge_last, hit;

  logic [AW-1:0]      rd_addr;
  logic               prev_load, idx_set_one, idx_inc, res_set;
  logic signed [31:0] res_value;
  plti_pkg::status_e  res_status;
  plti_pkg::lerp_req_t lerp_req;
  plti_pkg::lerp_rsp_t lerp_rsp;

  assign accept   = start && !busy;
  assign is_query = (mode_i == plti_pkg::MODE_QUERY);
  assign wr_en    = accept && (mode_i == plti_pkg::MODE_LOAD)
                    && (32'(point_index_i) < MAX_POINTS);
  assign wr_data  = '{x: point_x_i, y: point_y_i};

  assign n_pts    = (32'(points_q) > MAX_POINTS) ? 7'(MAX_POINTS) : points_q;
  assign last_idx = AW'(n_pts - 7'd1);

  // compares against the entry currently on the read port
  assign le_first = query_q <= $signed(rd_data.x);
  assign ge_last  = query_q >= $signed(rd_data.x);
  assign hit      = ($signed(prev_q.x) <= query_q) && le_first;

  plti_table #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(point_index_i)),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  plti_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .rsp_o  (lerp_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plti_pkg::SEQ_IDLE: begin
        if (accept && is_query && (n_pts != '0)) state_d = plti_pkg::SEQ_FIRST;
      end
      plti_pkg::SEQ_FIRST: begin
        state_d = le_first ? plti_pkg::SEQ_IDLE : plti_pkg::SEQ_LAST;
      end
      plti_pkg::SEQ_LAST: begin
        state_d = ge_last ? plti_pkg::SEQ_IDLE : plti_pkg::SEQ_SCAN;
      end
      plti_pkg::SEQ_SCAN: begin
        priority if (hit)                 state_d = plti_pkg::SEQ_LERP;
        else if (idx_q == last_idx)       state_d = plti_pkg::SEQ_IDLE;
        else                              state_d = plti_pkg::SEQ_SCAN;
      end
      plti_pkg::SEQ_LERP: begin
        if (lerp_rsp.done) state_d = plti_pkg::SEQ_IDLE;
      end
      default: state_d = plti_pkg::SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rd_addr        = '0;
    prev_load      = 1'b0;
    idx_set_one    = 1'b0;
    idx_inc        = 1'b0;
    res_set        = 1'b0;
    res_value      = '0;
    res_status     = plti_pkg::STATUS_NOT_FOUND;
    lerp_req       = '0;
    lerp_req.pa    = prev_q;
    lerp_req.pb    = rd_data;
    lerp_req.q     = query_q;
    unique case (state_q)
      plti_pkg::SEQ_IDLE: begin
        if (accept && is_query && (n_pts == '0)) begin
          res_set    = 1'b1;
          res_status = plti_pkg::STATUS_EMPTY;
        end
      end
      plti_pkg::SEQ_FIRST: begin
        prev_load = 1'b1;
        rd_addr   = last_idx;
        if (le_first) begin
          res_set    = 1'b1;
          res_value  = rd_data.y;
          res_status = plti_pkg::STATUS_CLAMP_LOW;
        end
      end
      plti_pkg::SEQ_LAST: begin
        rd_addr     = AW'(1);
        idx_set_one = 1'b1;
        if (ge_last) begin
          res_set    = 1'b1;
          res_value  = rd_data.y;
          res_status = plti_pkg::STATUS_CLAMP_HIGH;
        end
      end
      plti_pkg::SEQ_SCAN: begin
        priority if (hit) begin
          lerp_req.start = 1'b1;
        end else if (idx_q == last_idx) begin
          res_set = 1'b1;
        end else begin
          prev_load = 1'b1;
          idx_inc   = 1'b1;
          rd_addr   = AW'(idx_q + 1'b1);
        end
      end
      plti_pkg::SEQ_LERP: begin
        if (lerp_rsp.done) begin
          res_set    = 1'b1;
          res_value  = lerp_rsp.value;
          res_status = plti_pkg::STATUS_INTERIOR;
        end
      end
      default: begin
        res_set = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plti_pkg::SEQ_IDLE;
      points_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_set;
      if (cfg_we_i) begin
        points_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_query) begin
      query_q <= query_x_i;
    end
    if (prev_load) begin
      prev_q <= rd_data;
    end
    if (idx_set_one) begin
      idx_q <= AW'(1);
    end else if (idx_inc) begin
      idx_q <= AW'(idx_q + 1'b1);
    end
    if (res_set) begin
      res_value_q  <= res_value;
      res_status_q <= res_status;
    end
  end

  assign busy           = (state_q != plti_pkg::SEQ_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_value_o = res_value_q;
  assign status_o       = res_status_q;

  // a query on an empty table answers straight from idle with status EMPTY
  a_empty_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_query && (n_pts == '0))
      |=> (result_valid_o && (status_o == plti_pkg::STATUS_EMPTY)))
    else $error("empty-table query did not answer next cycle");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == plti_pkg::MODE_LOAD)) |=> !result_valid_o)
    else $error("load request produced a result");

  a_done_in_lerp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lerp_rsp.done |-> (state_q == plti_pkg::SEQ_LERP))
    else $error("interpolation finished outside the wait state");

  a_end_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("query finished without a result strobe");

endmodule

@@ rtl/plti_table.sv @@
// Breakpoint store: one write port, one registered read port.
module plti_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  plti_pkg::point_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output plti_pkg::point_t rdata_o
);

  plti_pkg::point_t mem_q [DEPTH];
  plti_pkg::point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/plti_lerp.sv @@
// Interval interpolation unit: one multiply, then a restoring divide one bit a cycle.
module plti_lerp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plti_pkg::lerp_req_t req_i,
  output plti_pkg::lerp_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(plti_pkg::DIV_STEPS);
  localparam logic [StepW-1:0] StepLast = StepW'(plti_pkg::DIV_STEPS - 1);

  plti_pkg::lerp_phase_e phase_q, phase_d;
  logic [StepW-1:0]      step_q;

  plti_pkg::point_t   pa_q, pb_q;
  logic signed [31:0] qx_q;
  logic [31:0]        dx_q, off_q, mag_q, rem_q, lo_q;
  logic               neg_q;

  logic [32:0] dx_w, off_w, dy_w, dy_abs_w;
  logic [63:0] prod_w;
  logic [32:0] part_w;
  logic        ge_w;

  assign dx_w     = {pb_q.x[31], pb_q.x} - {pa_q.x[31], pa_q.x};
  assign off_w    = {qx_q[31], qx_q} - {pa_q.x[31], pa_q.x};
  assign dy_w     = {pb_q.y[31], pb_q.y} - {pa_q.y[31], pa_q.y};
  assign dy_abs_w = dy_w[32] ? (33'd0 - dy_w) : dy_w;
  assign prod_w   = 64'(off_q) * 64'(mag_q);
  assign part_w   = {rem_q, lo_q[31]};
  assign ge_w     = part_w >= {1'b0, dx_q};

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      plti_pkg::LERP_IDLE: if (req_i.start) phase_d = plti_pkg::LERP_PREP;
      plti_pkg::LERP_PREP: phase_d = plti_pkg::LERP_MUL;
      plti_pkg::LERP_MUL: begin
        phase_d = (dx_q == '0) ? plti_pkg::LERP_FIN : plti_pkg::LERP_DIV;
      end
      plti_pkg::LERP_DIV: if (step_q == StepLast) phase_d = plti_pkg::LERP_FIN;
      plti_pkg::LERP_FIN: phase_d = plti_pkg::LERP_IDLE;
      default:            phase_d = plti_pkg::LERP_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done  = (phase_q == plti_pkg::LERP_FIN);
    rsp_o.value = neg_q ? (pa_q.y - $signed(lo_q)) : (pa_q.y + $signed(lo_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= plti_pkg::LERP_IDLE;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      if (phase_q == plti_pkg::LERP_DIV) begin
        step_q <= StepW'(step_q + 1'b1);
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      plti_pkg::LERP_IDLE: begin
        if (req_i.start) begin
          pa_q <= req_i.pa;
          pb_q <= req_i.pb;
          qx_q <= req_i.q;
        end
      end
      plti_pkg::LERP_PREP: begin
        dx_q  <= dx_w[31:0];
        off_q <= off_w[31:0];
        mag_q <= dy_abs_w[31:0];
        neg_q <= dy_w[32];
      end
      plti_pkg::LERP_MUL: begin
        // zero-width interval: quotient forced to zero, result is y_i
        if (dx_q == '0) begin
          lo_q <= '0;
        end else begin
          rem_q <= prod_w[63:32];
          lo_q  <= prod_w[31:0];
        end
      end
      plti_pkg::LERP_DIV: begin
        rem_q <= ge_w ? 32'(part_w - {1'b0, dx_q}) : part_w[31:0];
        lo_q  <= {lo_q[30:0], ge_w};
      end
      plti_pkg::LERP_FIN: begin
        lo_q <= lo_q;
      end
      default: begin
        lo_q <= lo_q;
      end
    endcase
  end

endmodule
